// ----- sv/rotd_pkg.sv -----
// Shared types and constants for the RTP-over-TCP deframer.
`default_nettype none
package rotd_pkg;

  // Largest packet that fits the downstream buffer.
  localparam logic [15:0] BufferBytes = 16'd4096;
  // Fixed RTP header size; longer packets are handed on.
  localparam logic [15:0] HeaderBytes = 16'd12;
  // Packet byte positions that hold the SSRC, big-endian.
  localparam logic [15:0] SsrcFirst   = 16'd8;
  localparam logic [15:0] SsrcLast    = 16'd11;

  // Queue between the framing front end and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One classified result as it travels through the queue.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        last;
    logic [15:0] length;
    logic [31:0] ssrc;
    logic        long_enough;
    logic        empty_frame;
    logic        too_long;
  } rotd_entry_t;

  // Queue occupancy as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } rotd_q_status_t;

endpackage
`default_nettype wire

// ----- sv/rtp_over_tcp_deframer.sv -----
// Top level of the RTP-over-TCP deframer: front end, result queue, output stage.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_ready_o   | stream_byte_i, new_connection_i
//   out     | output    | out_valid_o / out_ready_i | payload_byte_o, byte_index_o, last_o,
//           |           |                           | packet_length_o, source_id_o,
//           |           |                           | accepted_o, empty_frame_o, too_long_o
//
// One stream byte is taken per cycle while the queue has room; a payload byte is queued at its
// transfer edge, then loaded from the queue into the output register that drives the outputs.
// The two-entry queue sets the rate: the front end keeps taking bytes while it has room.
// Length-prefix bytes of a non-empty frame produce no result.
// Reset clears the framing state, empties the queue and drops the output valid.
// An output stall backs up into the queue; in_ready_o falls only once the queue is full.
`default_nettype none
module rtp_over_tcp_deframer import rotd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  input  wire logic        new_connection_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      byte_index_o,
  output logic             last_o,
  output logic [15:0]      packet_length_o,
  output logic [31:0]      source_id_o,
  output logic             accepted_o,
  output logic             empty_frame_o,
  output logic             too_long_o
);

  logic           push;
  rotd_entry_t    push_entry;
  logic           pop;
  rotd_entry_t    head;
  rotd_q_status_t q_status;

  // Classify bytes and advance the framing state on each input transfer.
  rotd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .new_connection_i (new_connection_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_entry_o     (push_entry)
  );

  // Decouple the two sides so each may stall on its own.
  rotd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Format and hold each result until the output transfer.
  rotd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .byte_index_o    (byte_index_o),
    .last_o          (last_o),
    .packet_length_o (packet_length_o),
    .source_id_o     (source_id_o),
    .accepted_o      (accepted_o),
    .empty_frame_o   (empty_frame_o),
    .too_long_o      (too_long_o)
  );

endmodule
`default_nettype wire

// ----- sv/rotd_front.sv -----
// Framing front end: tracks the length prefix and classifies each stream byte.
`default_nettype none
module rotd_front import rotd_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     stream_byte_i,
  input  wire logic           new_connection_i,
  input  wire rotd_q_status_t q_status_i,
  output logic                push_o,
  output rotd_entry_t         push_entry_o
);

  typedef enum logic [1:0] {
    PH_LEN_HI  = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_UNUSED  = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] length_q, length_d;
  logic [15:0] seen_q, seen_d;
  logic [31:0] shift_q, shift_d;

  phase_e      cur_phase;
  logic [15:0] cur_length;
  logic [15:0] cur_seen;
  logic [31:0] cur_shift;
  logic [15:0] low_length;
  logic [16:0] next_index;
  logic        is_last;
  logic        accept;
  logic        emit;
  rotd_entry_t entry;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // A new connection restarts framing before this byte is used.
    cur_phase  = new_connection_i ? PH_LEN_HI : phase_q;
    cur_length = new_connection_i ? 16'd0 : length_q;
    cur_seen   = new_connection_i ? 16'd0 : seen_q;
    cur_shift  = new_connection_i ? 32'd0 : shift_q;

    low_length = {cur_length[15:8], stream_byte_i};
    next_index = {1'b0, cur_seen} + 17'd1;
    is_last    = (next_index == {1'b0, cur_length});

    phase_d  = cur_phase;
    length_d = cur_length;
    seen_d   = cur_seen;
    shift_d  = cur_shift;
    emit     = 1'b0;
    entry    = '0;

    unique case (cur_phase)
      PH_LEN_LO: begin
        length_d = low_length;
        if (low_length == 16'd0) begin
          emit              = 1'b1;
          entry.last        = 1'b1;
          entry.empty_frame = 1'b1;
          phase_d           = PH_LEN_HI;
        end else begin
          seen_d  = 16'd0;
          shift_d = 32'd0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (cur_seen >= SsrcFirst && cur_seen <= SsrcLast) begin
          shift_d = {cur_shift[23:0], stream_byte_i};
        end
        emit               = 1'b1;
        entry.payload_byte = stream_byte_i;
        entry.byte_index   = cur_seen;
        entry.last         = is_last;
        entry.length       = cur_length;
        entry.ssrc         = shift_d;
        entry.long_enough  = (cur_length > HeaderBytes);
        entry.too_long     = (cur_length > BufferBytes);
        if (is_last) begin
          phase_d  = PH_LEN_HI;
          seen_d   = 16'd0;
          length_d = 16'd0;
        end else begin
          seen_d = next_index[15:0];
        end
      end
      default: begin
        // Length high byte; the unused code behaves the same way.
        length_d = {stream_byte_i, 8'h00};
        phase_d  = PH_LEN_LO;
      end
    endcase
  end

  assign push_o       = accept && emit;
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN_HI;
      length_q <= 16'd0;
      seen_q   <= 16'd0;
      shift_q  <= 32'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      seen_q   <= seen_d;
      shift_q  <= shift_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rotd_queue.sv -----
// Short result queue between the front end and the output stage.
`default_nettype none
module rotd_queue import rotd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire rotd_entry_t  push_entry_i,
  input  wire logic         pop_i,
  output rotd_entry_t       head_o,
  output rotd_q_status_t    status_o
);

  rotd_entry_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/rotd_back.sv -----
// Output stage: formats queued results and holds them until transferred.
`default_nettype none
module rotd_back import rotd_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rotd_entry_t    head_i,
  input  wire rotd_q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          payload_byte_o,
  output logic [15:0]         byte_index_o,
  output logic                last_o,
  output logic [15:0]         packet_length_o,
  output logic [31:0]         source_id_o,
  output logic                accepted_o,
  output logic                empty_frame_o,
  output logic                too_long_o
);

  logic        valid_q;
  logic [7:0]  byte_q;
  logic [15:0] index_q;
  logic        last_q;
  logic [15:0] length_q;
  logic [31:0] ssrc_q;
  logic        accepted_q;
  logic        empty_q;
  logic        too_long_q;
  logic        hand_on;

  // Load a new result whenever the output register is free or draining.
  assign pop_o   = !q_status_i.empty && (!valid_q || out_ready_i);
  assign hand_on = head_i.last && head_i.long_enough;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Length and SSRC only show on the last byte; drop them elsewhere.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q     <= head_i.payload_byte;
      index_q    <= head_i.byte_index;
      last_q     <= head_i.last;
      length_q   <= head_i.last ? head_i.length : 16'd0;
      ssrc_q     <= hand_on ? head_i.ssrc : 32'd0;
      accepted_q <= hand_on;
      empty_q    <= head_i.empty_frame;
      too_long_q <= head_i.too_long;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = byte_q;
  assign byte_index_o    = index_q;
  assign last_o          = last_q;
  assign packet_length_o = length_q;
  assign source_id_o     = ssrc_q;
  assign accepted_o      = accepted_q;
  assign empty_frame_o   = empty_q;
  assign too_long_o      = too_long_q;

endmodule
`default_nettype wire

// ----- sv/rotd_checker.sv -----
// Port-level checks for the RTP-over-TCP deframer, bound to the top level.
`default_nettype none
module rotd_checker import rotd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  payload_byte_o,
  input wire logic [15:0] byte_index_o,
  input wire logic        last_o,
  input wire logic [15:0] packet_length_o,
  input wire logic [31:0] source_id_o,
  input wire logic        accepted_o,
  input wire logic        empty_frame_o,
  input wire logic        too_long_o
);

  // Hold a stalled result unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(byte_index_o) && $stable(last_o))
    else $error("stalled output result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |-> last_o && payload_byte_o == 8'd0
      && byte_index_o == 16'd0 && packet_length_o == 16'd0)
    else $error("empty marker carries packet data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> packet_length_o == 16'd0 && source_id_o == 32'd0
      && !accepted_o)
    else $error("packet summary shown before the last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !empty_frame_o |->
      accepted_o == (packet_length_o > HeaderBytes)
      && too_long_o == (packet_length_o > BufferBytes)
      && byte_index_o == packet_length_o - 16'd1)
    else $error("last byte disagrees with its packet length");

endmodule

bind rtp_over_tcp_deframer rotd_checker u_rotd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .payload_byte_o  (payload_byte_o),
  .byte_index_o    (byte_index_o),
  .last_o          (last_o),
  .packet_length_o (packet_length_o),
  .source_id_o     (source_id_o),
  .accepted_o      (accepted_o),
  .empty_frame_o   (empty_frame_o),
  .too_long_o      (too_long_o)
);
`default_nettype wire

// ----- test/rtp_over_tcp_deframer_tb.sv -----
// Self-checking testbench for the RTP-over-TCP deframer: framed byte stream in, checked results out.
`timescale 1ns / 1ps
module rtp_over_tcp_deframer_tb;
  import rotd_pkg::*;

  // Framing phases of the predictor; the unused code acts as the length high byte.
  typedef enum logic [1:0] {
    WAIT_LEN_HI = 2'd0,
    WAIT_LEN_LO = 2'd1,
    IN_PAYLOAD  = 2'd2
  } frame_phase_e;

  // One byte of the TCP stream as offered on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       fresh;
  } stream_item_t;

  localparam int unsigned RandomTarget   = 2000;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned HoldOffAt      = 300;
  localparam int unsigned HoldOffCycles  = 400;
  localparam logic [15:0] OversizeLength = BufferBytes + 16'd1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte = 8'h00;
  logic        new_connection = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte_o;
  logic [15:0] byte_index_o;
  logic        last_o;
  logic [15:0] packet_length_o;
  logic [31:0] source_id_o;
  logic        accepted_o;
  logic        empty_frame_o;
  logic        too_long_o;

  rtp_over_tcp_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte),
    .new_connection_i (new_connection),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .last_o           (last_o),
    .packet_length_o  (packet_length_o),
    .source_id_o      (source_id_o),
    .accepted_o       (accepted_o),
    .empty_frame_o    (empty_frame_o),
    .too_long_o       (too_long_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stream bytes not yet offered, and results predicted but not yet seen.
  stream_item_t tcp_stream[$];
  rotd_entry_t  deframed_bytes[$];

  // Predictor state, mirrors the framing registers of the block.
  frame_phase_e fr_phase   = WAIT_LEN_HI;
  logic [15:0]  len_held   = '0;
  logic [15:0]  seen_count = '0;
  logic [31:0]  ssrc_shift = '0;

  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned fresh_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned packets_ended = 0;
  int unsigned packets_kept  = 0;
  int unsigned markers_seen  = 0;
  int unsigned oversize_seen = 0;
  int unsigned idle_cycles   = 0;

  // Stimulus builder: a pending cut forces new_connection on the next byte.
  logic cut_pending = 1'b1;

  task automatic push_byte(input logic [7:0] d, input logic nc);
    tcp_stream.push_back('{data: d, fresh: nc | cut_pending});
    cut_pending = 1'b0;
  endtask

  // Append one frame; stop after keep bytes and restart the connection if keep falls short.
  task automatic push_frame(input logic [15:0] len, input int unsigned keep);
    int unsigned total;
    int unsigned n;
    total = int'(len) + 2;
    for (n = 0; n < total && n < keep; n++) begin
      if (n == 0) begin
        push_byte(len[15:8], 1'b0);
      end else if (n == 1) begin
        push_byte(len[7:0], 1'b0);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if (keep < total) cut_pending = 1'b1;
  endtask

  // Mostly short gaps, a few long ones; none at all in a calm stretch.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the framing state by one stream byte and queue the result it causes.
  task automatic deframe_byte(input stream_item_t it);
    rotd_entry_t res;
    logic        is_last;
    logic        long_enough;
    res = '0;
    if (it.fresh) begin
      fr_phase   = WAIT_LEN_HI;
      len_held   = '0;
      seen_count = '0;
      ssrc_shift = '0;
    end
    case (fr_phase)
      WAIT_LEN_LO: begin
        len_held = len_held | {8'h00, it.data};
        if (len_held == 16'd0) begin
          // Zero-length frame: emit a lone empty marker.
          res.last        = 1'b1;
          res.empty_frame = 1'b1;
          deframed_bytes.push_back(res);
          fr_phase = WAIT_LEN_HI;
        end else begin
          seen_count = '0;
          ssrc_shift = '0;
          fr_phase   = IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        is_last     = ({1'b0, seen_count} + 17'd1) == {1'b0, len_held};
        long_enough = len_held > HeaderBytes;
        if (seen_count >= SsrcFirst && seen_count <= SsrcLast) begin
          ssrc_shift = {ssrc_shift[23:0], it.data};
        end
        res.payload_byte = it.data;
        res.byte_index   = seen_count;
        res.last         = is_last;
        res.length       = is_last ? len_held : 16'd0;
        res.ssrc         = (is_last && long_enough) ? ssrc_shift : 32'd0;
        res.long_enough  = is_last && long_enough;
        res.too_long     = len_held > BufferBytes;
        deframed_bytes.push_back(res);
        if (is_last) begin
          fr_phase   = WAIT_LEN_HI;
          seen_count = '0;
          len_held   = '0;
        end else begin
          seen_count = seen_count + 16'd1;
        end
      end
      default: begin
        len_held = {it.data, 8'h00};
        fr_phase = WAIT_LEN_LO;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Driver: offer the next stream byte, hold it until the transfer, then idle a while.
  stream_item_t offered;
  int unsigned  send_gap    = 0;
  bit           sender_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid       <= 1'b0;
      stream_byte    <= 8'h00;
      new_connection <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        deframe_byte(offered);
        bytes_sent++;
        if (offered.fresh) fresh_sent++;
        // Switch between idling and back-to-back stretches now and then.
        if (bytes_sent % 256 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        send_gap = pick_gap(sender_calm);
      end
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tcp_stream.size() > 0) begin
          offered = tcp_stream.pop_front();
          in_valid       <= 1'b1;
          stream_byte    <= offered.data;
          new_connection <= offered.fresh;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, then stall at random.
  rotd_entry_t want;
  int unsigned stall_left    = 0;
  int unsigned hold_off_left = 0;
  bit          receiver_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (last_o) packets_ended++;
        if (accepted_o) packets_kept++;
        if (empty_frame_o) markers_seen++;
        if (too_long_o) oversize_seen++;
        if (deframed_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual byte %0h index %0h",
                   $time, payload_byte_o, byte_index_o);
        end else begin
          want = deframed_bytes.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
          check_field("byte_index", 32'(want.byte_index), 32'(byte_index_o));
          check_field("last", 32'(want.last), 32'(last_o));
          check_field("packet_length", 32'(want.length), 32'(packet_length_o));
          check_field("source_id", want.ssrc, source_id_o);
          check_field("accepted", 32'(want.long_enough), 32'(accepted_o));
          check_field("empty_frame", 32'(want.empty_frame), 32'(empty_frame_o));
          check_field("too_long", 32'(want.too_long), 32'(too_long_o));
        end
        if (results_seen % 200 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
        stall_left = pick_gap(receiver_calm);
        // Hold off once for a long stretch so the queue fills and stalls the input.
        if (results_seen == HoldOffAt) hold_off_left = HoldOffCycles;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Count cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles without a transfer, %0d results outstanding",
             $time, WatchdogLimit, deframed_bytes.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Build the stream, release reset, wait for the drain, then report.
  initial begin : stimulus
    int unsigned    n;
    int unsigned    pick;
    int unsigned    keep;
    logic [15:0]    len;
    logic [7:0]     d;

    // Directed: empty frame right at the first byte of the connection.
    push_frame(16'd0, 2);
    // One-byte packet.
    push_frame(16'd1, 3);
    // Thirteen-byte packet with a known SSRC and extreme byte values.
    push_byte(8'h00, 1'b0);
    push_byte(8'h0D, 1'b0);
    for (n = 0; n < 13; n++) begin
      case (n)
        0:       d = 8'hFF;
        1:       d = 8'h00;
        8:       d = 8'hDE;
        9:       d = 8'hAD;
        10:      d = 8'hBE;
        11:      d = 8'hEF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      push_byte(d, 1'b0);
    end
    // New connection between the two length bytes.
    push_frame(16'h0700, 1);
    // Largest announced length, cut short by a new connection.
    push_frame(16'hFFFF, 5);
    // Length just over the buffer size, cut short after a few dozen bytes.
    push_frame(OversizeLength, 40);

    // Random frames: mostly well formed, some cut short, a few with oversize lengths.
    while (tcp_stream.size() < RandomTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        len = 16'd0;
      end else if (pick < 20) begin
        len = 16'($urandom_range(1, 12));
      end else if (pick < 30) begin
        len = HeaderBytes + 16'($urandom_range(0, 1));
      end else if (pick < 92) begin
        len = 16'($urandom_range(13, 48));
      end else begin
        len = 16'($urandom_range(49, 300));
      end
      keep = int'(len) + 2;
      if ($urandom_range(0, 99) < 8) keep = $urandom_range(1, int'(len) + 1);
      if ($urandom_range(0, 99) < 3) cut_pending = 1'b1;
      if ($urandom_range(0, 99) < 2) begin
        len  = 16'($urandom_range(int'(OversizeLength), 65535));
        keep = $urandom_range(2, 60);
      end
      push_frame(len, keep);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tcp_stream.size() != 0 || in_valid) @(posedge clk_i);
    while (deframed_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d stream bytes (%0d new connections) and %0d checked results.",
             bytes_sent, fresh_sent, results_seen);
    $display("Packets ended %0d, handed on %0d, empty markers %0d, oversize bytes %0d.",
             packets_ended, packets_kept, markers_seen, oversize_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
